// File: src/double_ended_queue_assert.svh
// Assertion macros for the deque RTL, used by its controller.
// Each macro checks a clocked implication and is disabled while reset is asserted.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("double_ended_queue: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double_ended_queue: assertion failed");

`endif

// File: src/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int WORD_W         = 32;
    localparam int OP_W           = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What every cell of one lane does in a cycle.
    typedef enum logic [1:0] {
        LANE_HOLD   = 2'd0,
        LANE_PUSH   = 2'd1,
        LANE_POP    = 2'd2,
        LANE_APPEND = 2'd3
    } t_lane_op;

    typedef struct packed {
        t_lane_op a_op;
        t_lane_op b_op;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_A    = 2'd1,
        HEAD_B    = 2'd2
    } t_head_sel;

endpackage

`default_nettype wire

// File: src/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_cell #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                         i_clk,
    input  wire dq_pkg::t_cell_ctl            i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_count,
    input  wire logic [DATA_WIDTH-1:0]        i_value,
    input  wire logic [DATA_WIDTH-1:0]        i_a_prev,
    input  wire logic [DATA_WIDTH-1:0]        i_b_prev,
    input  wire logic [DATA_WIDTH-1:0]        i_a_next,
    input  wire logic [DATA_WIDTH-1:0]        i_b_next,
    output logic      [DATA_WIDTH-1:0]        o_a,
    output logic      [DATA_WIDTH-1:0]        o_b
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [DATA_WIDTH-1:0] n_a;
    logic [DATA_WIDTH-1:0] n_b;
    logic                  at_tail;

    // The cell just past the last held element takes an appended word.
    assign at_tail = (i_count == MY_IDX);

    always_comb begin
        n_a = r_a;
        case (i_ctl.a_op)
            LANE_PUSH:   n_a = i_a_prev;
            LANE_POP:    n_a = i_a_next;
            LANE_APPEND: if (at_tail) begin
                n_a = i_value;
            end
            default:     n_a = r_a;
        endcase
    end

    always_comb begin
        n_b = r_b;
        case (i_ctl.b_op)
            LANE_PUSH:   n_b = i_b_prev;
            LANE_POP:    n_b = i_b_next;
            LANE_APPEND: if (at_tail) begin
                n_b = i_value;
            end
            default:     n_b = r_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

`default_nettype wire

// File: src/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_assert.svh"

module dq_ctrl #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [dq_pkg::OP_W-1:0]        i_operation,
    input  wire logic [dq_pkg::WORD_W-1:0]      i_value,
    input  wire logic [DATA_WIDTH-1:0]          i_a_head,
    input  wire logic [DATA_WIDTH-1:0]          i_b_head,
    output dq_pkg::t_cell_ctl                   o_ctl,
    output logic      [DATA_WIDTH-1:0]          o_value,
    output logic                                o_done,
    output dq_pkg::t_status                     o_status,
    output logic      [dq_pkg::WORD_W-1:0]      o_data,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                  r_ready;
    logic                  r_done;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_status               r_status;
    t_status               n_status;
    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] head_word;
    t_head_sel             head_sel;
    t_op                   op;
    logic                  accept;
    logic                  full;
    logic                  empty;

    assign busy   = ~r_ready;
    assign accept = start & r_ready;
    assign full   = (r_count == FULL_CNT);
    assign empty  = (r_count == '0);
    assign op     = t_op'(i_operation);

    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        head_sel     = HEAD_NONE;
        o_ctl.a_op   = LANE_HOLD;
        o_ctl.b_op   = LANE_HOLD;
        if (accept) begin
            case (op)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.a_op = LANE_PUSH;
                        o_ctl.b_op = LANE_APPEND;
                        n_count    = r_count + 1'b1;
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.b_op = LANE_PUSH;
                        o_ctl.a_op = LANE_APPEND;
                        n_count    = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        head_sel   = HEAD_A;
                        o_ctl.a_op = LANE_POP;
                        n_count    = r_count - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        head_sel   = HEAD_B;
                        o_ctl.b_op = LANE_POP;
                        n_count    = r_count - 1'b1;
                    end
                end
                OP_PEEK_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        head_sel = HEAD_A;
                    end
                end
                OP_PEEK_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        head_sel = HEAD_B;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_comb begin
        case (head_sel)
            HEAD_A:  head_word = i_a_head;
            HEAD_B:  head_word = i_b_head;
            default: head_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_word   <= head_word;
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_count  = r_count;

    generate
        if (DATA_WIDTH == WORD_W) begin : g_same
            assign o_value = i_value;
            assign o_data  = r_word;
        end else if (DATA_WIDTH < WORD_W) begin : g_narrow
            assign o_value = i_value[DATA_WIDTH-1:0];
            assign o_data  = {{(WORD_W - DATA_WIDTH){r_word[DATA_WIDTH-1]}}, r_word};
        end else begin : g_wide
            assign o_value = {{(DATA_WIDTH - WORD_W){i_value[WORD_W-1]}}, i_value};
            assign o_data  = r_word[WORD_W-1:0];
        end
    endgenerate

    `DQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, r_ready, r_count <= FULL_CNT)
    `DQ_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, accept, o_done)
    `DQ_ASSERT_IMPLY(a_err_no_data, i_clk, i_rst_n, o_done && (o_status != ST_OK), o_data == '0)
    `DQ_ASSERT_IMPLY(a_full_at_depth, i_clk, i_rst_n, o_done && (o_status == ST_FULL), o_count == FULL_CNT)
    `DQ_ASSERT_IMPLY(a_empty_at_zero, i_clk, i_rst_n, o_done && (o_status == ST_EMPTY), o_count == '0)

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// A request taken at one clock edge has its result on the outputs, with o_done high, for
// exactly the next cycle. Throughput: one request per cycle, every cycle, set by the single
// register stage of the cell row and the count register; the result side cannot stall.
// Reset is synchronous and active low: the count clears, busy stays high through reset and the
// first cycle after it, and the cell contents are left as they are.

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [dq_pkg::OP_W-1:0]      i_operation,
    input  wire logic [dq_pkg::WORD_W-1:0]    i_value,
    output logic                              o_done,
    output dq_pkg::t_status                   o_status,
    output logic      [dq_pkg::WORD_W-1:0]    o_data,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);
    import dq_pkg::*;

    // The queue is kept twice, in two lanes that run through one row of cells.
    // Lane A holds the elements front first, so cell 0 of lane A is always the front.
    // Lane B holds them back first, so cell 0 of lane B is always the back.
    // A push at one end shifts that end's lane one cell up and drops the word into
    // cell 0; the other lane takes the same word at the cell whose index equals the
    // old count. A pop shifts its own lane one cell down; the other lane simply loses
    // its last element through the count. Every access therefore lands on cell 0 or on
    // a cell picked by comparing its own index with the broadcast count.

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] lane_a [DEPTH];
    logic [DATA_WIDTH-1:0] lane_b [DEPTH];
    logic [DATA_WIDTH-1:0] value_w;
    t_cell_ctl             cell_ctl;
    logic [CNT_W-1:0]      count;

    // The controller decodes each request, keeps the element count and registers
    // the result, reading the front and back words straight from cell 0.
    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_a_head    (lane_a[0]),
        .i_b_head    (lane_b[0]),
        .o_ctl       (cell_ctl),
        .o_value     (value_w),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_count     (count)
    );

    assign o_count = count;

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] a_prev;
            logic [DATA_WIDTH-1:0] b_prev;
            logic [DATA_WIDTH-1:0] a_next;
            logic [DATA_WIDTH-1:0] b_next;

            // Cell 0 receives the pushed word when its lane shifts up.
            if (g == 0) begin : g_first
                assign a_prev = value_w;
                assign b_prev = value_w;
            end else begin : g_inner_prev
                assign a_prev = lane_a[g-1];
                assign b_prev = lane_b[g-1];
            end

            // The last cell keeps its own word on a pop; it lies past the held elements.
            if (g == DEPTH - 1) begin : g_last
                assign a_next = lane_a[g];
                assign b_next = lane_b[g];
            end else begin : g_inner_next
                assign a_next = lane_a[g+1];
                assign b_next = lane_b[g+1];
            end

            dq_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (cell_ctl),
                .i_count  (count),
                .i_value  (value_w),
                .i_a_prev (a_prev),
                .i_b_prev (b_prev),
                .i_a_next (a_next),
                .i_b_next (b_next),
                .o_a      (lane_a[g]),
                .o_b      (lane_b[g])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// File: test/tb_double_ended_queue.sv
`timescale 1ns / 1ps

// Self-checking bench for the double-ended queue.
// A behavioral mirror of the deque predicts the status, word and count of every request
// at the moment the block accepts it. One checker process compares each strobed result
// with the oldest prediction, field by field.
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int DATA_WIDTH     = DATA_WIDTH_DEF;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    // Code 7 has no member in the package enum. The block treats it as a no-op.
    localparam logic [OP_W-1:0] OP_NOP = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_ZERO = 32'h0000_0000;

    // One predicted answer, in the order that the block returns its fields.
    typedef struct {
        t_status            status;
        logic [WORD_W-1:0]  data;
        logic [CNT_W-1:0]   count;
    } t_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       i_operation;
    logic [WORD_W-1:0]     i_value;
    logic                  o_done;
    t_status               o_status;
    logic [WORD_W-1:0]     o_data;
    logic [CNT_W-1:0]      o_count;

    // Mirror of the deque: circular storage, front index and element count.
    logic [WORD_W-1:0]     mirror_words [DEPTH];
    int unsigned           mirror_front;
    int unsigned           mirror_count;

    // Answers that have been predicted but not yet seen on the result ports.
    t_answer               pending_answers [$];

    int                    mismatches;
    int                    idle_percent;
    int                    idle_cycles;
    int                    n_requests;
    int                    n_results;
    int                    n_full_errors;
    int                    n_empty_errors;
    int                    n_clears;
    int unsigned           peak_count;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_count     (o_count)
    );

    // The clock runs at an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Applies one request to the mirror and returns the answer the block must give.
    // A pop or peek reads only held elements, so no word is ever read before it is written.
    task automatic mirror_apply(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val,
                                output t_answer answer);
        bit          full;
        bit          empty;
        int unsigned idx;
        full          = (mirror_count >= DEPTH);
        empty         = (mirror_count == 0);
        answer.status = ST_OK;
        answer.data   = '0;
        case (op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    answer.status = ST_FULL;
                end else begin
                    mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                    mirror_words[mirror_front] = val;
                    mirror_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    answer.status = ST_FULL;
                end else begin
                    mirror_words[(mirror_front + mirror_count) % DEPTH] = val;
                    mirror_count++;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (empty) begin
                    answer.status = ST_EMPTY;
                end else begin
                    answer.data = mirror_words[mirror_front];
                    if (op == OP_POP_FRONT) begin
                        mirror_front = (mirror_front + 1) % DEPTH;
                        mirror_count--;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (empty) begin
                    answer.status = ST_EMPTY;
                end else begin
                    idx = (mirror_front + mirror_count - 1) % DEPTH;
                    answer.data = mirror_words[idx];
                    if (op == OP_POP_BACK) begin
                        mirror_count--;
                    end
                end
            end
            OP_CLEAR: begin
                mirror_front = 0;
                mirror_count = 0;
                n_clears++;
            end
            default: begin
                // The spare code leaves the queue as it is.
            end
        endcase
        answer.count = mirror_count[CNT_W-1:0];
        if (answer.status == ST_FULL) n_full_errors++;
        if (answer.status == ST_EMPTY) n_empty_errors++;
        if (mirror_count > peak_count) peak_count = mirror_count;
    endtask

    // Sends one request. Random idle cycles come first; start then stays high until the
    // block takes the request, and stays high afterwards unless the next call idles.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
        t_answer answer;
        while ($urandom_range(0, 99) < idle_percent) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        mirror_apply(op, val, answer);
        pending_answers.insert(pending_answers.size(), answer);
        n_requests++;
    endtask

    // Draws an operation from the given weights; the side of a push, pop or peek is random.
    function automatic logic [OP_W-1:0] pick_op(input int push_w, input int pop_w,
                                                 input int peek_w, input int clear_w,
                                                 input int nop_w);
        int r;
        bit back_side;
        r         = $urandom_range(0, push_w + pop_w + peek_w + clear_w + nop_w - 1);
        back_side = 1'($urandom_range(0, 1));
        if (r < push_w) return back_side ? OP_PUSH_BACK : OP_PUSH_FRONT;
        r -= push_w;
        if (r < pop_w) return back_side ? OP_POP_BACK : OP_POP_FRONT;
        r -= pop_w;
        if (r < peek_w) return back_side ? OP_PEEK_BACK : OP_PEEK_FRONT;
        r -= peek_w;
        if (r < clear_w) return OP_CLEAR;
        return OP_NOP;
    endfunction

    // Mostly uniform words, with the extremes mixed in now and then.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return WORD_ONES;
            3:       return WORD_ZERO;
            default: return $urandom;
        endcase
    endfunction

    // Every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            n_results++;
            if (pending_answers.size() == 0) begin
                report_mismatch("result strobed with no request outstanding");
            end else begin
                want = pending_answers[0];
                pending_answers.delete(0);
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                end
                if (o_data !== want.data) begin
                    report_mismatch($sformatf("data %h, expected %h", o_data, want.data));
                end
                if (o_count !== want.count) begin
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              o_count, want.count));
                end
            end
        end
    end

    // The watchdog ends the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("double_ended_queue regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Right after reset the queue is empty: every pop and peek is refused, and a no-op
    // reports a count of zero.
    task automatic test_empty_after_reset();
        send_request(OP_POP_FRONT, rand_word());
        send_request(OP_POP_BACK, rand_word());
        send_request(OP_PEEK_FRONT, rand_word());
        send_request(OP_PEEK_BACK, rand_word());
        send_request(OP_NOP, rand_word());
    endtask

    // Extreme words at both ends, reads from both ends, the no-op code, and clear
    // followed by reads and pushes.
    task automatic test_directed_ops();
        send_request(OP_PUSH_BACK, WORD_MAX);
        send_request(OP_PUSH_FRONT, WORD_MIN);
        send_request(OP_PUSH_BACK, WORD_ONES);
        send_request(OP_PUSH_FRONT, WORD_ZERO);
        send_request(OP_PEEK_FRONT, WORD_ONES);
        send_request(OP_PEEK_BACK, WORD_ZERO);
        send_request(OP_NOP, WORD_ONES);
        send_request(OP_POP_FRONT, rand_word());
        send_request(OP_POP_BACK, rand_word());
        send_request(OP_POP_FRONT, rand_word());
        send_request(OP_POP_BACK, rand_word());
        send_request(OP_POP_BACK, rand_word());
        send_request(OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(OP_PUSH_BACK, 32'h5555_5555);
        send_request(OP_CLEAR, WORD_ONES);
        send_request(OP_PEEK_BACK, rand_word());
        send_request(OP_PUSH_BACK, 32'h1234_5678);
        send_request(OP_PEEK_FRONT, rand_word());
        send_request(OP_CLEAR, WORD_ZERO);
    endtask

    // Fills the queue from both ends until it holds DEPTH words. The first stretch runs
    // with no idle cycles at all, so requests arrive back to back.
    task automatic test_fill_to_full();
        int sent;
        sent = 0;
        while (mirror_count < DEPTH) begin
            idle_percent = (sent < 400) ? 0 : 23;
            send_request(pick_op(97, 2, 1, 0, 0), rand_word());
            sent++;
        end
        idle_percent = 23;
    endtask

    // At full, pushes on either side are refused and leave the queue alone; pops make
    // room that the following pushes take again.
    task automatic test_full_pressure();
        send_request(OP_PUSH_FRONT, rand_word());
        send_request(OP_PUSH_BACK, rand_word());
        send_request(OP_PEEK_BACK, rand_word());
        repeat (60) send_request(pick_op(50, 20, 20, 0, 10), rand_word());
    endtask

    // Pops mostly, which reads back a long run of stored words across the wrap point,
    // and then clears a well-filled queue.
    task automatic test_drain_and_clear();
        repeat (100) send_request(pick_op(10, 80, 10, 0, 0), rand_word());
        send_request(OP_CLEAR, rand_word());
        send_request(OP_POP_FRONT, rand_word());
    endtask

    // A loose mix near empty: clears, no-ops and empty errors come often here.
    task automatic test_random_mix();
        repeat (60) send_request(pick_op(40, 28, 20, 4, 8), rand_word());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_NOP;
        i_value      = '0;
        mirror_front = 0;
        mirror_count = 0;
        mismatches   = 0;
        idle_percent = 23;
        idle_cycles  = 0;
        n_requests   = 0;
        n_results    = 0;
        n_full_errors  = 0;
        n_empty_errors = 0;
        n_clears     = 0;
        peak_count   = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_after_reset();
        test_directed_ops();
        test_random_mix();
        test_fill_to_full();
        test_full_pressure();
        test_drain_and_clear();
        test_random_mix();

        // Stop requesting, let the last results come back, then keep the clock running
        // in case the block strobes anything it should not.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results, peak count %0d of %0d",
                 n_requests, n_results, peak_count, DEPTH);
        $display("refusals: %0d full, %0d empty; %0d clears; %0d mismatches",
                 n_full_errors, n_empty_errors, n_clears, mismatches);
        if (mismatches == 0) begin
            $display("double_ended_queue regression: pass");
        end else begin
            $display("double_ended_queue regression: fail");
        end
        $finish;
    end

endmodule
